// ===== sv/gtft_pkg.sv =====
// ----------------------------------------------------------------------------
// gtft_pkg
// Shared types and constants for the gradient transfer function table.
// ----------------------------------------------------------------------------
package gtft_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CHAN_W = 16;
  localparam int unsigned VAL_W  = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE      = 3'd0,
    CMD_ADD_COLOUR  = 3'd1,
    CMD_ADD_OPACITY = 3'd2,
    CMD_RM_COLOUR   = 3'd3,
    CMD_RM_OPACITY  = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    ST_INIT0, ST_INIT1, ST_IDLE, ST_DECODE, ST_RD, ST_CMP, ST_EVAL, ST_TBL_END,
    ST_MUL1, ST_MUL2, ST_SUM, ST_DIV, ST_STORE, ST_SH_CHK, ST_SH_RD, ST_SH_WR,
    ST_RM_CHK, ST_RM_RD, ST_RM_WR, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT0, OP_INIT1, OP_LOAD, OP_SETK_IDX, OP_RD, OP_ADV, OP_HIT,
    OP_TAKE_CUR, OP_TAKE_PREV, OP_NEXT, OP_CHAN_INIT, OP_MUL1, OP_MUL2, OP_SUM,
    OP_DIV, OP_STORE, OP_SLOT, OP_SH_RD, OP_SH_WR, OP_WR_NEW, OP_RM_RD, OP_RM_WR,
    OP_RM_FIN, OP_PUSH
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic is_sample;
    logic is_add;
    logic is_rm;
    logic full;
    logic rm_bad;
    logic below;
    logic last;
    logic ptr_zero;
    logic ptr_end;
    logic k_at_slot;
    logic rm_last;
    logic div_last;
    logic chan_zero;
    logic tsel;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/gtft_ram.sv =====
// ----------------------------------------------------------------------------
// gtft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gtft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gtft_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtft_ctrl
// Sequencer for search, interpolation, table shifts and result handoff.
// ----------------------------------------------------------------------------
module gtft_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gtft_pkg::stat_t stat_i,
  output gtft_pkg::ctrl_t ctrl_o
);

  gtft_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtft_pkg::ST_INIT0;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o.op  = gtft_pkg::OP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      gtft_pkg::ST_INIT0: begin
        ctrl_o.op = gtft_pkg::OP_INIT0;
        state_d   = gtft_pkg::ST_INIT1;
      end
      gtft_pkg::ST_INIT1: begin
        ctrl_o.op = gtft_pkg::OP_INIT1;
        state_d   = gtft_pkg::ST_IDLE;
      end
      gtft_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = gtft_pkg::OP_LOAD;
          state_d   = gtft_pkg::ST_DECODE;
        end
      end
      gtft_pkg::ST_DECODE: begin
        priority if (stat_i.is_sample) begin
          state_d = gtft_pkg::ST_RD;
        end else if (stat_i.is_add) begin
          state_d = stat_i.full ? gtft_pkg::ST_DONE : gtft_pkg::ST_RD;
        end else if (stat_i.is_rm && !stat_i.rm_bad) begin
          ctrl_o.op = gtft_pkg::OP_SETK_IDX;
          state_d   = gtft_pkg::ST_RM_CHK;
        end else begin
          state_d = gtft_pkg::ST_DONE;
        end
      end
      gtft_pkg::ST_RD: begin
        ctrl_o.op = gtft_pkg::OP_RD;
        state_d   = gtft_pkg::ST_CMP;
      end
      gtft_pkg::ST_CMP: begin
        if (stat_i.below) begin
          ctrl_o.op = gtft_pkg::OP_ADV;
          state_d   = stat_i.last ? gtft_pkg::ST_EVAL : gtft_pkg::ST_RD;
        end else begin
          ctrl_o.op = gtft_pkg::OP_HIT;
          state_d   = gtft_pkg::ST_EVAL;
        end
      end
      gtft_pkg::ST_EVAL: begin
        priority if (stat_i.is_add) begin
          ctrl_o.op = gtft_pkg::OP_SLOT;
          state_d   = gtft_pkg::ST_SH_CHK;
        end else if (stat_i.ptr_zero) begin
          ctrl_o.op = gtft_pkg::OP_TAKE_CUR;
          state_d   = gtft_pkg::ST_TBL_END;
        end else if (stat_i.ptr_end) begin
          ctrl_o.op = gtft_pkg::OP_TAKE_PREV;
          state_d   = gtft_pkg::ST_TBL_END;
        end else begin
          ctrl_o.op = gtft_pkg::OP_CHAN_INIT;
          state_d   = gtft_pkg::ST_MUL1;
        end
      end
      gtft_pkg::ST_TBL_END: begin
        if (!stat_i.tsel) begin
          ctrl_o.op = gtft_pkg::OP_NEXT;
          state_d   = gtft_pkg::ST_RD;
        end else begin
          state_d = gtft_pkg::ST_DONE;
        end
      end
      gtft_pkg::ST_MUL1: begin
        ctrl_o.op = gtft_pkg::OP_MUL1;
        state_d   = gtft_pkg::ST_MUL2;
      end
      gtft_pkg::ST_MUL2: begin
        ctrl_o.op = gtft_pkg::OP_MUL2;
        state_d   = gtft_pkg::ST_SUM;
      end
      gtft_pkg::ST_SUM: begin
        ctrl_o.op = gtft_pkg::OP_SUM;
        state_d   = gtft_pkg::ST_DIV;
      end
      gtft_pkg::ST_DIV: begin
        ctrl_o.op = gtft_pkg::OP_DIV;
        if (stat_i.div_last) begin
          state_d = gtft_pkg::ST_STORE;
        end
      end
      gtft_pkg::ST_STORE: begin
        ctrl_o.op = gtft_pkg::OP_STORE;
        state_d   = stat_i.chan_zero ? gtft_pkg::ST_TBL_END : gtft_pkg::ST_MUL1;
      end
      gtft_pkg::ST_SH_CHK: begin
        if (stat_i.k_at_slot) begin
          ctrl_o.op = gtft_pkg::OP_WR_NEW;
          state_d   = gtft_pkg::ST_DONE;
        end else begin
          state_d = gtft_pkg::ST_SH_RD;
        end
      end
      gtft_pkg::ST_SH_RD: begin
        ctrl_o.op = gtft_pkg::OP_SH_RD;
        state_d   = gtft_pkg::ST_SH_WR;
      end
      gtft_pkg::ST_SH_WR: begin
        ctrl_o.op = gtft_pkg::OP_SH_WR;
        state_d   = gtft_pkg::ST_SH_CHK;
      end
      gtft_pkg::ST_RM_CHK: begin
        if (stat_i.rm_last) begin
          ctrl_o.op = gtft_pkg::OP_RM_FIN;
          state_d   = gtft_pkg::ST_DONE;
        end else begin
          state_d = gtft_pkg::ST_RM_RD;
        end
      end
      gtft_pkg::ST_RM_RD: begin
        ctrl_o.op = gtft_pkg::OP_RM_RD;
        state_d   = gtft_pkg::ST_RM_WR;
      end
      gtft_pkg::ST_RM_WR: begin
        ctrl_o.op = gtft_pkg::OP_RM_WR;
        state_d   = gtft_pkg::ST_RM_CHK;
      end
      gtft_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.op = gtft_pkg::OP_PUSH;
          state_d   = gtft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gtft_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/gtft_dp.sv =====
// ----------------------------------------------------------------------------
// gtft_dp
// Marker memories, search pointer, interpolation multiplier and serial divider.
// ----------------------------------------------------------------------------
module gtft_dp #(
  parameter int unsigned MAX_MARKERS        = 16,
  parameter int unsigned LOCATION_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gtft_pkg::ctrl_t                   ctrl_i,
  output gtft_pkg::stat_t                   stat_o,
  input  logic [gtft_pkg::CMD_W-1:0]        cmd_i,
  input  logic [LOCATION_FRAC_BITS:0]       location_i,
  input  logic [gtft_pkg::VAL_W-1:0]        marker_value_i,
  input  logic [gtft_pkg::IDX_W-1:0]        index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gtft_pkg::CHAN_W-1:0]       red_o,
  output logic [gtft_pkg::CHAN_W-1:0]       green_o,
  output logic [gtft_pkg::CHAN_W-1:0]       blue_o,
  output logic [gtft_pkg::CHAN_W-1:0]       opacity_o,
  output logic                              ok_o,
  output logic [gtft_pkg::IDX_W-1:0]        new_index_o
);

  localparam int unsigned LW  = LOCATION_FRAC_BITS + 1;
  localparam int unsigned AW  = $clog2(MAX_MARKERS);
  localparam int unsigned CW  = $clog2(MAX_MARKERS + 1);
  localparam int unsigned XW  = (CW > 5) ? CW : 5;
  localparam int unsigned CHW = gtft_pkg::CHAN_W;
  localparam int unsigned VW  = gtft_pkg::VAL_W;
  localparam int unsigned PW  = CHW + LW;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned RW  = NW - CHW;
  localparam int unsigned BW  = $clog2(CHW + 1);
  localparam int unsigned CWC = LW + VW;
  localparam int unsigned OWC = LW + CHW;
  localparam logic [LW-1:0] LOC_ONE = LW'(1) << LOCATION_FRAC_BITS;

  // item and search registers
  logic [gtft_pkg::CMD_W-1:0] cmd_q;
  logic [LW-1:0]              x_q;
  logic [VW-1:0]              val_q;
  logic [gtft_pkg::IDX_W-1:0] idx_q;
  logic                       tsel_q;
  logic [CW-1:0]              ptr_q, slot_q;
  logic [CW-1:0]              cnt_col_q, cnt_op_q;
  logic [LW-1:0]              prev_loc_q, cur_loc_q;
  logic [VW-1:0]              prev_val_q, cur_val_q;
  logic [1:0]                 chan_q;
  logic [PW-1:0]              p1_q, p2_q;
  logic [RW-1:0]              rem_q;
  logic [CHW-1:0]             quo_q;
  logic [BW-1:0]              bc_q;
  logic [CHW-1:0]             r_q, g_q, b_q, o_q;
  logic                       ok_q;
  logic [gtft_pkg::IDX_W-1:0] nidx_q;
  logic                       out_valid_q;
  logic [CHW-1:0]             red_q, green_q, blue_q, opa_q;
  logic                       ok_out_q;
  logic [gtft_pkg::IDX_W-1:0] nidx_out_q;

  // memory ports
  logic           col_we, op_we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [LW-1:0]  wloc;
  logic [VW-1:0]  wval;
  logic [CWC-1:0] col_rdata;
  logic [OWC-1:0] op_rdata;
  logic [LW-1:0]  rloc;
  logic [VW-1:0]  rval;

  logic [CW-1:0]  cnt;
  logic [LW-1:0]  x_in, d, n;
  logic [CHW-1:0] a_ch, b_ch;
  logic [NW-1:0]  num;
  logic [RW:0]    rem2, rem_sub;
  logic           ge;
  logic [XW-1:0]  slot_x, idx_x, cnt_x;
  logic [CW-1:0]  slot_p;
  logic           is_cmd_col;

  assign cnt   = tsel_q ? cnt_op_q : cnt_col_q;
  assign x_in  = (location_i > LOC_ONE) ? LOC_ONE : location_i;
  assign rloc  = tsel_q ? op_rdata[OWC-1:CHW] : col_rdata[CWC-1:VW];
  assign rval  = tsel_q ? VW'(op_rdata[CHW-1:0]) : col_rdata[VW-1:0];
  assign d     = cur_loc_q - prev_loc_q;
  assign n     = x_q - prev_loc_q;
  assign a_ch  = prev_val_q[chan_q*CHW +: CHW];
  assign b_ch  = cur_val_q[chan_q*CHW +: CHW];
  assign num   = NW'(p1_q) + NW'(p2_q) + NW'(d >> 1);
  assign rem2  = {rem_q, quo_q[CHW-1]};
  assign ge    = rem2 >= (RW+1)'(d);
  assign rem_sub = rem2 - (RW+1)'(d);
  assign slot_x = XW'(slot_q);
  assign idx_x  = XW'(idx_q);
  assign cnt_x  = XW'(cnt);
  assign is_cmd_col = (cmd_i == gtft_pkg::CMD_SAMPLE) || (cmd_i == gtft_pkg::CMD_ADD_COLOUR)
                   || (cmd_i == gtft_pkg::CMD_RM_COLOUR);

  // insert slot clamped to lie strictly between the end markers
  always_comb begin
    slot_p = ptr_q;
    if (ptr_q == '0) begin
      slot_p = CW'(1);
    end
    if (ptr_q >= cnt) begin
      slot_p = cnt - CW'(1);
    end
  end

  // memory addressing
  always_comb begin
    col_we = 1'b0;
    op_we  = 1'b0;
    re     = 1'b0;
    waddr  = ptr_q[AW-1:0];
    raddr  = ptr_q[AW-1:0];
    wloc   = rloc;
    wval   = rval;
    unique case (ctrl_i.op)
      gtft_pkg::OP_INIT0: begin
        col_we = 1'b1;
        op_we  = 1'b1;
        waddr  = '0;
        wloc   = '0;
        wval   = '0;
      end
      gtft_pkg::OP_INIT1: begin
        col_we = 1'b1;
        op_we  = 1'b1;
        waddr  = AW'(1);
        wloc   = LOC_ONE;
        wval   = '1;
      end
      gtft_pkg::OP_RD: begin
        re = 1'b1;
      end
      gtft_pkg::OP_SH_RD: begin
        re    = 1'b1;
        raddr = AW'(ptr_q - CW'(1));
      end
      gtft_pkg::OP_RM_RD: begin
        re    = 1'b1;
        raddr = AW'(ptr_q + CW'(1));
      end
      gtft_pkg::OP_SH_WR, gtft_pkg::OP_RM_WR: begin
        col_we = !tsel_q;
        op_we  = tsel_q;
      end
      gtft_pkg::OP_WR_NEW: begin
        col_we = !tsel_q;
        op_we  = tsel_q;
        waddr  = slot_q[AW-1:0];
        wloc   = x_q;
        wval   = val_q;
      end
      default: begin
      end
    endcase
  end

  gtft_ram #(.WIDTH(CWC), .DEPTH(MAX_MARKERS)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (waddr),
    .wdata_i ({wloc, wval}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (col_rdata)
  );

  // opacity row 0 resets to full opacity as well
  gtft_ram #(.WIDTH(OWC), .DEPTH(MAX_MARKERS)) u_op_ram (
    .clk_i   (clk_i),
    .we_i    (op_we),
    .waddr_i (waddr),
    .wdata_i ({wloc, (ctrl_i.op == gtft_pkg::OP_INIT0) ? {CHW{1'b1}} : wval[CHW-1:0]}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (op_rdata)
  );

  // counts and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_col_q   <= CW'(2);
      cnt_op_q    <= CW'(2);
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == gtft_pkg::OP_WR_NEW) begin
        if (tsel_q) cnt_op_q <= cnt_op_q + CW'(1);
        else        cnt_col_q <= cnt_col_q + CW'(1);
      end else if (ctrl_i.op == gtft_pkg::OP_RM_FIN) begin
        if (tsel_q) cnt_op_q <= cnt_op_q - CW'(1);
        else        cnt_col_q <= cnt_col_q - CW'(1);
      end
      if (ctrl_i.op == gtft_pkg::OP_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      gtft_pkg::OP_LOAD: begin
        cmd_q  <= cmd_i;
        x_q    <= x_in;
        val_q  <= marker_value_i;
        idx_q  <= index_i;
        tsel_q <= !is_cmd_col;
        ptr_q  <= '0;
        r_q    <= '0;
        g_q    <= '0;
        b_q    <= '0;
        o_q    <= '0;
        ok_q   <= (cmd_i == gtft_pkg::CMD_SAMPLE);
        nidx_q <= '0;
      end
      gtft_pkg::OP_SETK_IDX: ptr_q <= CW'(idx_q);
      gtft_pkg::OP_ADV: begin
        prev_loc_q <= rloc;
        prev_val_q <= rval;
        ptr_q      <= ptr_q + CW'(1);
      end
      gtft_pkg::OP_HIT: begin
        cur_loc_q <= rloc;
        cur_val_q <= rval;
      end
      gtft_pkg::OP_TAKE_CUR: begin
        if (tsel_q) begin
          o_q <= cur_val_q[CHW-1:0];
        end else begin
          r_q <= cur_val_q[3*CHW-1:2*CHW];
          g_q <= cur_val_q[2*CHW-1:CHW];
          b_q <= cur_val_q[CHW-1:0];
        end
      end
      gtft_pkg::OP_TAKE_PREV: begin
        if (tsel_q) begin
          o_q <= prev_val_q[CHW-1:0];
        end else begin
          r_q <= prev_val_q[3*CHW-1:2*CHW];
          g_q <= prev_val_q[2*CHW-1:CHW];
          b_q <= prev_val_q[CHW-1:0];
        end
      end
      gtft_pkg::OP_NEXT: begin
        tsel_q <= 1'b1;
        ptr_q  <= '0;
      end
      gtft_pkg::OP_CHAN_INIT: chan_q <= tsel_q ? 2'd0 : 2'd2;
      gtft_pkg::OP_MUL1: p1_q <= PW'(a_ch) * PW'(d - n);
      gtft_pkg::OP_MUL2: p2_q <= PW'(b_ch) * PW'(n);
      gtft_pkg::OP_SUM: begin
        // quotient fits 16 bits, so the high part already sits below d
        rem_q <= num[NW-1:CHW];
        quo_q <= num[CHW-1:0];
        bc_q  <= BW'(CHW);
      end
      gtft_pkg::OP_DIV: begin
        rem_q <= ge ? rem_sub[RW-1:0] : rem2[RW-1:0];
        quo_q <= {quo_q[CHW-2:0], ge};
        bc_q  <= bc_q - BW'(1);
      end
      gtft_pkg::OP_STORE: begin
        if (tsel_q) begin
          o_q <= quo_q;
        end else begin
          unique case (chan_q)
            2'd2:    r_q <= quo_q;
            2'd1:    g_q <= quo_q;
            default: b_q <= quo_q;
          endcase
        end
        chan_q <= chan_q - 2'd1;
      end
      gtft_pkg::OP_SLOT: begin
        slot_q <= slot_p;
        ptr_q  <= cnt;
      end
      gtft_pkg::OP_SH_WR: ptr_q <= ptr_q - CW'(1);
      gtft_pkg::OP_RM_WR: ptr_q <= ptr_q + CW'(1);
      gtft_pkg::OP_WR_NEW: begin
        ok_q   <= 1'b1;
        nidx_q <= slot_x[gtft_pkg::IDX_W-1:0];
      end
      gtft_pkg::OP_RM_FIN: ok_q <= 1'b1;
      gtft_pkg::OP_PUSH: begin
        red_q      <= r_q;
        green_q    <= g_q;
        blue_q     <= b_q;
        opa_q      <= o_q;
        ok_out_q   <= ok_q;
        nidx_out_q <= nidx_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.is_sample = (cmd_q == gtft_pkg::CMD_SAMPLE);
    stat_o.is_add    = (cmd_q == gtft_pkg::CMD_ADD_COLOUR)
                    || (cmd_q == gtft_pkg::CMD_ADD_OPACITY);
    stat_o.is_rm     = (cmd_q == gtft_pkg::CMD_RM_COLOUR)
                    || (cmd_q == gtft_pkg::CMD_RM_OPACITY);
    stat_o.full      = (cnt == CW'(MAX_MARKERS));
    stat_o.rm_bad    = (idx_q == '0) || ((idx_x + XW'(1)) >= cnt_x);
    stat_o.below     = (rloc < x_q);
    stat_o.last      = ((ptr_q + CW'(1)) == cnt);
    stat_o.ptr_zero  = (ptr_q == '0);
    stat_o.ptr_end   = (ptr_q == cnt);
    stat_o.k_at_slot = (ptr_q == slot_q);
    stat_o.rm_last   = ((ptr_q + CW'(1)) == cnt);
    stat_o.div_last  = (bc_q == BW'(1));
    stat_o.chan_zero = (chan_q == 2'd0);
    stat_o.tsel      = tsel_q;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign opacity_o   = opa_q;
  assign ok_o        = ok_out_q;
  assign new_index_o = nidx_out_q;

endmodule

// ===== sv/gradient_transfer_function_table.sv =====
// ----------------------------------------------------------------------------
// gradient_transfer_function_table
// sample: scans the markers of each table in turn; each interpolated channel
//   goes through one shared 16-step divider
// insert: scans markers, then shifts entries up; remove: shifts entries down;
//   one item at a time, next accepted once the result is queued
// reset: ST_INIT0, ST_INIT1 write both tables' end markers before input is taken
// ----------------------------------------------------------------------------
module gradient_transfer_function_table #(
  parameter int unsigned MAX_MARKERS        = 16,
  parameter int unsigned LOCATION_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gtft_pkg::CMD_W-1:0]  cmd_i,
  input  logic [LOCATION_FRAC_BITS:0] location_i,
  input  logic [gtft_pkg::VAL_W-1:0]  marker_value_i,
  input  logic [gtft_pkg::IDX_W-1:0]  index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gtft_pkg::CHAN_W-1:0] red_o,
  output logic [gtft_pkg::CHAN_W-1:0] green_o,
  output logic [gtft_pkg::CHAN_W-1:0] blue_o,
  output logic [gtft_pkg::CHAN_W-1:0] opacity_o,
  output logic                        ok_o,
  output logic [gtft_pkg::IDX_W-1:0]  new_index_o
);

  gtft_pkg::ctrl_t ctrl;
  gtft_pkg::stat_t stat;

  gtft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  gtft_dp #(
    .MAX_MARKERS        (MAX_MARKERS),
    .LOCATION_FRAC_BITS (LOCATION_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .location_i     (location_i),
    .marker_value_i (marker_value_i),
    .index_i        (index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .opacity_o      (opacity_o),
    .ok_o           (ok_o),
    .new_index_o    (new_index_o)
  );

endmodule
